// ----- sv/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
package spq_pkg;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic        command;
		logic [31:0] item;
		logic [15:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [31:0] out_item;
		logic [15:0] out_priority;
		logic [1:0]  status;
		logic        is_empty;
	} rsp_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic        exec;
		logic        cmd;
		logic [31:0] item;
		logic [15:0] prio;
	} op_t;

	// what one cell shows its neighbors
	typedef struct packed {
		logic        valid;
		logic        shift;
		logic [31:0] item;
		logic [15:0] prio;
	} link_t;

endpackage

// ----- sv/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue: command register, cell chain, result register.
//
//  channel | handshake              | payload       | direction
//  --------+------------------------+---------------+----------
//  req     | req_valid / req_ready  | req_t  (req)  | in
//  rsp     | rsp_valid / rsp_ready  | rsp_t  (rsp)  | out
//
// Each transaction first latches the command into cmd_q; then every cell
// loads from its left or right neighbor (or the new entry) and the result
// register loads. The next request is taken while a result waits.
// A stalled result holds the latched command until the result register frees.
// Reset clears the cell valid bits and the handshake flags; stored entries
// and the latched command have no reset, and there is no clearing pass.
module sorted_priority_queue_top
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic  busy_q;     // a command waits in cmd_q
	req_t  cmd_q;
	logic  out_valid_q;
	rsp_t  rsp_q;
	logic  fire;       // result register loads this cycle; cells update unless the command is refused
	logic  full;
	logic  empty;
	op_t   op;
	rsp_t  rsp_d;
	link_t head_tie;
	link_t tail_tie;
	link_t links [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] vld;

	assign req_ready = !busy_q;
	assign fire      = busy_q && (!out_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			busy_q <= 1'b1;
		end else if (fire) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q <= req;
		end
	end

	// head of the chain: cell 0 sees a valid, never-shifting left neighbor
	assign head_tie = '{valid: 1'b1, shift: 1'b0, item: '0, prio: '0};
	// tail: an empty cell shifts into the last place on remove
	assign tail_tie = '{valid: 1'b0, shift: 1'b0, item: '0, prio: '0};

	assign full  = links[QUEUE_DEPTH-1].valid;
	assign empty = !links[0].valid;

	// insert on full and remove on empty leave the cells untouched
	assign op.exec = fire && !((cmd_q.command == CMD_INSERT) && full)
		&& !((cmd_q.command == CMD_REMOVE) && empty);
	assign op.cmd  = cmd_q.command;
	assign op.item = cmd_q.item;
	assign op.prio = cmd_q.priority_req;

	generate
		for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			link_t left_l;
			link_t right_l;
			if (i == 0) begin : g_first
				assign left_l = head_tie;
			end else begin : g_mid_l
				assign left_l = links[i-1];
			end
			if (i == QUEUE_DEPTH - 1) begin : g_last
				assign right_l = tail_tie;
			end else begin : g_mid_r
				assign right_l = links[i+1];
			end
			spq_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.op    (op),
				.left  (left_l),
				.right (right_l),
				.self  (links[i])
			);
			assign vld[i] = links[i].valid;
		end
	endgenerate

	// result from the state before the update
	always_comb begin
		rsp_d = '0;
		if (cmd_q.command == CMD_REMOVE) begin
			if (empty) begin
				rsp_d.status   = ST_EMPTY;
				rsp_d.is_empty = 1'b1;
			end else begin
				rsp_d.out_item     = links[0].item;
				rsp_d.out_priority = links[0].prio;
				rsp_d.status       = ST_OK;
				rsp_d.is_empty     = !links[1].valid;
			end
		end else begin
			rsp_d.status   = full ? ST_FULL : ST_OK;
			rsp_d.is_empty = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	// occupied cells always form a prefix of the chain
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((vld >> 1) & ~vld) == '0)
		else $error("cell chain has a hole");

	// an accepted insert into a non-full queue leaves the head occupied
	a_insert_head: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (cmd_q.command == CMD_INSERT) && !full) |=> links[0].valid)
		else $error("insert left head empty");

	// an empty-queue remove always reports an empty queue
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == ST_EMPTY)) |-> rsp.is_empty)
		else $error("empty status without empty flag");

	// a latched command executes only once: fire never repeats back to back
	a_update_once: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> !fire)
		else $error("command executed twice");

endmodule

// ----- sv/spq_cell.sv -----
// One storage cell of the sorted chain.
module spq_cell
	import spq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  op_t   op,
	input  link_t left,
	input  link_t right,
	output link_t self
);

	logic        valid_q;
	logic [31:0] item_q;
	logic [15:0] prio_q;
	logic        load;
	logic        valid_d;
	logic [31:0] item_d;
	logic [15:0] prio_d;
	logic        yields;

	// new entry belongs at or before this cell
	assign yields = !valid_q || (prio_q <= op.prio);

	always_comb begin
		load    = 1'b0;
		valid_d = valid_q;
		item_d  = item_q;
		prio_d  = prio_q;
		if (op.exec) begin
			if (op.cmd == CMD_REMOVE) begin
				load    = 1'b1;
				valid_d = right.valid;
				item_d  = right.item;
				prio_d  = right.prio;
			end else if (left.shift) begin
				load    = 1'b1;
				valid_d = left.valid;
				item_d  = left.item;
				prio_d  = left.prio;
			end else if (left.valid && yields) begin
				load    = 1'b1;
				valid_d = 1'b1;
				item_d  = op.item;
				prio_d  = op.prio;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item_d;
			prio_q <= prio_d;
		end
	end

	assign self.valid = valid_q;
	assign self.shift = valid_q && (prio_q <= op.prio);
	assign self.item  = item_q;
	assign self.prio  = prio_q;

endmodule

// ----- tb/spq_result_checker.sv -----
// Result checker for the sorted priority queue: tracks the queue contents and compares each result.
`timescale 1ns / 1ps

module spq_result_checker
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   errors,
	output int   outstanding
);

	// sorted copy of the stored entries, head at index 0
	logic [31:0] held_item [QUEUE_DEPTH];
	logic [15:0] held_prio [QUEUE_DEPTH];
	int          held_count;

	rsp_t        awaited_results [$];
	rsp_t        want;
	int          fail_count = 0;
	int          rsp_seen = 0;

	task automatic report_mismatch(input string what);
		$display("%0t ns: transaction %0d: %s", $time, rsp_seen, what);
		fail_count++;
	endtask

	// applies one command to the tracked contents, returns the result it should give
	function automatic rsp_t apply_queue_op(input req_t r);
		rsp_t res;
		int   pos;
		int   i;
		res = '0;
		res.status = ST_OK;
		if (r.command == CMD_INSERT) begin
			if (held_count >= QUEUE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				pos = 0;
				// ties go in front of the older entries
				while (pos < held_count && held_prio[pos] > r.priority_req)
					pos++;
				for (i = held_count; i > pos; i--) begin
					held_item[i] = held_item[i - 1];
					held_prio[i] = held_prio[i - 1];
				end
				held_item[pos] = r.item;
				held_prio[pos] = r.priority_req;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.out_item = held_item[0];
				res.out_priority = held_prio[0];
				for (i = 1; i < held_count; i++) begin
					held_item[i - 1] = held_item[i];
					held_prio[i - 1] = held_prio[i];
				end
				held_count--;
			end
		end
		res.is_empty = (held_count == 0);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			awaited_results.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with no command awaiting it");
				end else begin
					want = awaited_results.pop_front();
					if (rsp.out_item !== want.out_item)
						report_mismatch($sformatf("out_item %h, want %h",
							rsp.out_item, want.out_item));
					if (rsp.out_priority !== want.out_priority)
						report_mismatch($sformatf("out_priority %h, want %h",
							rsp.out_priority, want.out_priority));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp.status, want.status));
					if (rsp.is_empty !== want.is_empty)
						report_mismatch($sformatf("is_empty %b, want %b",
							rsp.is_empty, want.is_empty));
				end
				rsp_seen++;
			end
			if (req_valid && req_ready)
				awaited_results.push_back(apply_queue_op(req));
		end
		errors <= fail_count;
		outstanding <= awaited_results.size();
	end

endmodule

// ----- tb/sorted_priority_queue_top_tb.sv -----
// Testbench top for the sorted priority queue: clock, reset, command traffic and the verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;
	import spq_pkg::*;

	localparam int QUEUE_DEPTH = 64;
	// receiver hold-off long enough to back the block up into its input
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 90;
	localparam int NUM_PHASES  = 15;
	localparam int HOLD_ITEMS  = 40;

	// traffic shapes: which side idles, and how often
	typedef enum int {
		TR_NONE,
		TR_SEND_IDLE,
		TR_RECV_STALL,
		TR_BOTH,
		TR_HOLD
	} traffic_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	req_t     req = '0;
	logic     rsp_ready = 1'b0;
	logic     req_ready;
	logic     rsp_valid;
	rsp_t     rsp;

	traffic_t traffic = TR_NONE;
	int       hold_done = 0;
	int       errors;
	int       outstanding;

	sorted_priority_queue_top #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	spq_result_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side. In the hold phase the receiver refuses results until
	// hold_done, counted here, reaches HOLD_CYCLES, so the block's result
	// register and latched command both fill and req_ready drops. The count
	// is never rearmed, so the long stall happens exactly once.
	always @(posedge clk) begin
		case (traffic)
			TR_HOLD: begin
				if (hold_done < HOLD_CYCLES) begin
					rsp_ready <= 1'b0;
					hold_done <= hold_done + 1;
				end else begin
					rsp_ready <= 1'b1;
				end
			end
			TR_RECV_STALL: rsp_ready <= ($urandom_range(99) >= 61);
			TR_BOTH:       rsp_ready <= ($urandom_range(99) >= 25);
			default:       rsp_ready <= 1'b1;
		endcase
	end

	// Offers one command and returns once it has been taken. An idle gap
	// first drops valid; with no gap valid stays high straight into the
	// next transaction, so it is never lowered and raised in one step.
	task automatic send_req(input req_t r, input int idle_pct);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// A run of random commands. insert_pct steers the fill level: a high
	// value drives the queue to full (dropped inserts), a low one drains it
	// to empty (removes on empty), the middle keeps it churning.
	task automatic run_phase(input int n, input int insert_pct, input traffic_t mode);
		req_t r;
		int   idle_pct;
		traffic <= mode;
		idle_pct = (mode == TR_SEND_IDLE) ? 61 : (mode == TR_BOTH) ? 25 : 0;
		for (int k = 0; k < n; k++) begin
			r.command = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
			r.item = $urandom();
			// narrow priorities give plenty of ties, extremes hit the ends
			case ($urandom_range(3))
				0:       r.priority_req = 16'($urandom_range(7));
				1:       r.priority_req = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				default: r.priority_req = 16'($urandom());
			endcase
			send_req(r, idle_pct);
		end
	endtask

	initial begin
		int      wait_cycles;
		traffic_t mode;
		int      fill_pct;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: remove on empty with junk in the ignored fields, field
		// extremes, ties in the middle and at the tail, then drain past empty.
		send_req('{CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF}, 0);
		send_req('{CMD_INSERT, 32'h0000_0000, 16'h0000}, 0);
		send_req('{CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF}, 0);
		send_req('{CMD_INSERT, 32'h1234_5678, 16'h0005}, 0);
		send_req('{CMD_INSERT, 32'h8765_4321, 16'h0005}, 0);
		send_req('{CMD_INSERT, 32'hA5A5_A5A5, 16'h0000}, 0);
		send_req('{CMD_INSERT, 32'h5A5A_5A5A, 16'h8000}, 0);
		repeat (7) send_req('{CMD_REMOVE, 32'h0000_0000, 16'h0000}, 0);

		// Random: fill / drain / churn crossed with the four traffic shapes.
		// The long receiver hold-off comes right after the first fill, so
		// the sender keeps pushing into a full queue behind a blocked output.
		for (int b = 0; b < NUM_PHASES; b++) begin
			case (b % 3)
				0:       fill_pct = 95;
				1:       fill_pct = 5;
				default: fill_pct = 50;
			endcase
			case (b % 4)
				0:       mode = TR_NONE;
				1:       mode = TR_SEND_IDLE;
				2:       mode = TR_RECV_STALL;
				default: mode = TR_BOTH;
			endcase
			run_phase(PHASE_ITEMS, fill_pct, mode);
			if (b == 0)
				run_phase(HOLD_ITEMS, 50, TR_HOLD);
		end

		req_valid <= 1'b0;
		traffic <= TR_NONE;

		// drain what is still in flight, then keep watching for results
		// nobody asked for
		wait_cycles = 0;
		while (outstanding != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);

		if (errors == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sorted_priority_queue_top.f -----
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_top.sv
tb/spq_result_checker.sv
tb/sorted_priority_queue_top_tb.sv
